[rtl/ecu_pkg.sv]
package ecu_pkg;

  // Handshake status reported by the serial arithmetic units.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

[rtl/elgamal_cipher_unit.sv]
// ElGamal encryption and decryption modulo a configured prime.
// Input transactions arrive on the s_axis channel: tuser carries the
// operation (0 encrypt, 1 decrypt), tdata the value_a, value_b and nonce
// fields. Each input transaction produces exactly one output transaction
// on m_axis: tdata carries result_first and result_second, tuser the
// no_inverse flag. The cfg channel writes modulus, generator, private key
// and public key (indexes 0 to 3); it is always ready and should be used
// only while the unit is idle.
// One item is processed at a time. All arithmetic runs through a bit-serial
// modular multiplier and a bit-serial divider. An exponentiation costs up
// to 2*MOD_BITS such multiplications; encryption takes two exponentiations,
// and decryption one exponentiation plus three unit operations per Euclid
// step.
// A finished result sits in an output register; the next input transaction
// is accepted while it waits, and the unit stalls at the end of that item
// only if the receiver still has not taken the earlier result.
// Reset restores the configuration registers to their default values and
// empties the output register.
module elgamal_cipher_unit import ecu_pkg::*; #(
  parameter int MOD_BITS = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // value_a, value_b, nonce from bit 0 up, zero padded to whole bytes.
  input  logic [((3*MOD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // op.
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // result_first, result_second from bit 0 up, zero padded to whole bytes.
  output logic [((2*MOD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // no_inverse.
  output logic                 m_axis_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index_i,
  input  logic [MOD_BITS-1:0]  cfg_data_i
);

  localparam int W     = MOD_BITS;
  localparam int TDO_W = ((2*MOD_BITS+7)/8)*8;

  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_GEN     = 2'd1;
  localparam logic [1:0] REG_PRIV    = 2'd2;
  localparam logic [1:0] REG_PUB     = 2'd3;

  localparam logic [1:0] RET_C1   = 2'd0;
  localparam logic [1:0] RET_MASK = 2'd1;
  localparam logic [1:0] RET_S    = 2'd2;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_G_RED   = 5'd1;
  localparam logic [4:0] ST_Y_RED   = 5'd2;
  localparam logic [4:0] ST_A_RED   = 5'd3;
  localparam logic [4:0] ST_C2_MUL  = 5'd4;
  localparam logic [4:0] ST_C1_RED  = 5'd5;
  localparam logic [4:0] ST_PW_CHK  = 5'd6;
  localparam logic [4:0] ST_PW_MUL  = 5'd7;
  localparam logic [4:0] ST_PW_SQR  = 5'd8;
  localparam logic [4:0] ST_RET     = 5'd9;
  localparam logic [4:0] ST_EU_CHK  = 5'd10;
  localparam logic [4:0] ST_EU_DIV  = 5'd11;
  localparam logic [4:0] ST_EU_QM   = 5'd12;
  localparam logic [4:0] ST_EU_MUL  = 5'd13;
  localparam logic [4:0] ST_B_RED   = 5'd14;
  localparam logic [4:0] ST_INV_MUL = 5'd15;
  localparam logic [4:0] ST_OUT     = 5'd16;

  // Configuration registers.
  logic [W-1:0] modulus_q, gen_q, priv_q, pub_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= W'(11);
      gen_q     <= W'(2);
      priv_q    <= W'(8);
      pub_q     <= W'(3);
    end else if (cfg_valid) begin
      case (cfg_index_i)
        REG_MODULUS: modulus_q <= cfg_data_i;
        REG_GEN:     gen_q     <= cfg_data_i;
        REG_PRIV:    priv_q    <= cfg_data_i;
        REG_PUB:     pub_q     <= cfg_data_i;
        default:     modulus_q <= modulus_q;
      endcase
    end
  end

  // Sequencer registers.
  logic [4:0]   state_q, state_d;
  logic [1:0]   ret_q, ret_d;
  logic         issued_q, issued_d;
  logic [W-1:0] p_q, p_d, a_q, a_d, b_q, b_d, r_q, r_d;
  logic [W-1:0] base_q, base_d, acc_q, acc_d, e_q, e_d, tmp_q, tmp_d;
  logic [W-1:0] r0_q, r0_d, r1_q, r1_d, rn_q, rn_d, t0_q, t0_d, t1_q, t1_d;
  logic [W-1:0] res1_q, res1_d, res2_q, res2_d;
  logic         flag_q, flag_d;
  logic [W-1:0] out1_q, out1_d, out2_q, out2_d;
  logic         outf_q, outf_d, outv_q, outv_d;

  // Shared arithmetic units.
  logic         div_state, mul_state, div_start, mul_start;
  logic [W-1:0] div_num, div_den, div_quot, div_rem;
  logic [W-1:0] mul_a, mul_b, mul_y;
  logic [W-1:0] one_mod;
  unit_status_t div_st, mul_st;

  assign one_mod = W'(p_q != W'(1));

  assign div_state = (state_q inside {ST_G_RED, ST_Y_RED, ST_A_RED, ST_C1_RED,
                                      ST_EU_DIV, ST_EU_QM, ST_B_RED});
  assign mul_state = (state_q inside {ST_PW_MUL, ST_PW_SQR, ST_C2_MUL,
                                      ST_EU_MUL, ST_INV_MUL});
  assign div_start = div_state && !issued_q;
  assign mul_start = mul_state && !issued_q;

  always_comb begin
    div_num = a_q;
    div_den = p_q;
    case (state_q)
      ST_G_RED:  div_num = gen_q;
      ST_Y_RED:  div_num = pub_q;
      ST_EU_DIV: begin
        div_num = r0_q;
        div_den = r1_q;
      end
      ST_EU_QM:  div_num = tmp_q;
      ST_B_RED:  div_num = b_q;
      default:   div_num = a_q;
    endcase
  end

  always_comb begin
    mul_a = acc_q;
    mul_b = base_q;
    case (state_q)
      ST_PW_SQR:  mul_a = base_q;
      ST_C2_MUL:  mul_b = tmp_q;
      ST_EU_MUL: begin
        mul_a = tmp_q;
        mul_b = t1_q;
      end
      ST_INV_MUL: begin
        mul_a = tmp_q;
        mul_b = t0_q;
      end
      default:    mul_b = base_q;
    endcase
  end

  ecu_divmod #(.W(W)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .quot_o   (div_quot),
    .rem_o    (div_rem),
    .status_o (div_st)
  );

  ecu_mulmod #(.W(W)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .m_i      (p_q),
    .y_o      (mul_y),
    .status_o (mul_st)
  );

  logic unit_done;
  assign unit_done = (div_state && div_st.done) || (mul_state && mul_st.done);

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    issued_d = issued_q;
    p_d = p_q;  a_d = a_q;  b_d = b_q;  r_d = r_q;
    base_d = base_q;  acc_d = acc_q;  e_d = e_q;  tmp_d = tmp_q;
    r0_d = r0_q;  r1_d = r1_q;  rn_d = rn_q;  t0_d = t0_q;  t1_d = t1_q;
    res1_d = res1_q;  res2_d = res2_q;  flag_d = flag_q;
    out1_d = out1_q;  out2_d = out2_q;  outf_d = outf_q;
    outv_d = outv_q && !m_axis_tready;

    if (div_start || mul_start) begin
      issued_d = 1'b1;
    end
    if (unit_done) begin
      issued_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          a_d    = s_axis_tdata[W-1:0];
          b_d    = s_axis_tdata[2*W-1:W];
          r_d    = s_axis_tdata[3*W-1:2*W];
          p_d    = modulus_q;
          res1_d = '0;
          res2_d = '0;
          flag_d = 1'b0;
          if (modulus_q == '0) begin
            state_d = ST_OUT;
          end else if (s_axis_tuser) begin
            state_d = ST_C1_RED;
          end else begin
            state_d = ST_G_RED;
          end
        end
      end
      ST_G_RED, ST_Y_RED, ST_C1_RED: begin
        if (unit_done) begin
          base_d  = div_rem;
          acc_d   = one_mod;
          e_d     = (state_q == ST_C1_RED) ? priv_q : r_q;
          ret_d   = (state_q == ST_G_RED) ? RET_C1 :
                    (state_q == ST_Y_RED) ? RET_MASK : RET_S;
          state_d = ST_PW_CHK;
        end
      end
      ST_PW_CHK: begin
        if (e_q == '0) begin
          state_d = ST_RET;
        end else if (e_q[0]) begin
          state_d = ST_PW_MUL;
        end else begin
          state_d = ST_PW_SQR;
        end
      end
      ST_PW_MUL: begin
        if (unit_done) begin
          acc_d   = mul_y;
          state_d = ST_PW_SQR;
        end
      end
      ST_PW_SQR: begin
        if (unit_done) begin
          base_d  = mul_y;
          e_d     = {1'b0, e_q[W-1:1]};
          state_d = ST_PW_CHK;
        end
      end
      ST_RET: begin
        case (ret_q)
          RET_C1: begin
            res1_d  = acc_q;
            state_d = ST_Y_RED;
          end
          RET_MASK: state_d = ST_A_RED;
          default: begin
            r0_d    = p_q;
            r1_d    = acc_q;
            t0_d    = '0;
            t1_d    = one_mod;
            state_d = ST_EU_CHK;
          end
        endcase
      end
      ST_A_RED: begin
        if (unit_done) begin
          tmp_d   = div_rem;
          state_d = ST_C2_MUL;
        end
      end
      ST_C2_MUL: begin
        if (unit_done) begin
          res2_d  = mul_y;
          state_d = ST_OUT;
        end
      end
      ST_EU_CHK: begin
        if (r1_q != '0) begin
          state_d = ST_EU_DIV;
        end else if (r0_q != W'(1)) begin
          flag_d  = 1'b1;
          state_d = ST_OUT;
        end else begin
          state_d = ST_B_RED;
        end
      end
      ST_EU_DIV: begin
        if (unit_done) begin
          tmp_d   = div_quot;
          rn_d    = div_rem;
          state_d = ST_EU_QM;
        end
      end
      ST_EU_QM: begin
        if (unit_done) begin
          tmp_d   = div_rem;
          state_d = ST_EU_MUL;
        end
      end
      ST_EU_MUL: begin
        if (unit_done) begin
          t1_d    = (t0_q >= mul_y) ? (t0_q - mul_y) : (t0_q + (p_q - mul_y));
          t0_d    = t1_q;
          r0_d    = r1_q;
          r1_d    = rn_q;
          state_d = ST_EU_CHK;
        end
      end
      ST_B_RED: begin
        if (unit_done) begin
          tmp_d   = div_rem;
          state_d = ST_INV_MUL;
        end
      end
      ST_INV_MUL: begin
        if (unit_done) begin
          res1_d  = mul_y;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hand over once the output register is free or being emptied.
        if (!outv_q || m_axis_tready) begin
          out1_d  = res1_q;
          out2_d  = res2_q;
          outf_d  = flag_q;
          outv_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      outv_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      outv_q   <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q  <= ret_d;
    p_q  <= p_d;   a_q <= a_d;   b_q <= b_d;   r_q <= r_d;
    base_q <= base_d; acc_q <= acc_d; e_q <= e_d;  tmp_q <= tmp_d;
    r0_q   <= r0_d;   r1_q <= r1_d;  rn_q <= rn_d; t0_q <= t0_d; t1_q <= t1_d;
    res1_q <= res1_d; res2_q <= res2_d; flag_q <= flag_d;
    out1_q <= out1_d; out2_q <= out2_d; outf_q <= outf_d;
  end

  assign m_axis_tvalid = outv_q;
  assign m_axis_tdata  = TDO_W'({out2_q, out1_q});
  assign m_axis_tuser  = outf_q;

endmodule

[rtl/ecu_divmod.sv]
// Restoring divider, one quotient bit per cycle, most significant first.
module ecu_divmod import ecu_pkg::*; #(
  parameter int W = 31
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o,
  output unit_status_t status_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  num_q, den_q, quot_q, rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W:0]    trial;
  logic          fits;

  assign trial = {rem_q, num_q[W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[W-2:0], 1'b0};
      rem_q  <= fits ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
      quot_q <= {quot_q[W-2:0], fits};
    end
  end

  assign quot_o   = quot_q;
  assign rem_o    = rem_q;
  assign status_o = '{busy: busy_q, done: done_q};

endmodule

[rtl/ecu_mulmod.sv]
// Modular multiplier by double-and-add, one multiplier bit per cycle.
// Both operands must already be below the modulus.
module ecu_mulmod import ecu_pkg::*; #(
  parameter int W = 31
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] m_i,
  output logic [W-1:0] y_o,
  output unit_status_t status_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  a_q, b_q, m_q, acc_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W:0]    acc_sum, dbl;

  assign acc_sum = {1'b0, acc_q} + {1'b0, a_q};
  assign dbl     = {a_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      m_q   <= m_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= (acc_sum >= {1'b0, m_q}) ? W'(acc_sum - {1'b0, m_q}) : acc_sum[W-1:0];
      end
      a_q <= (dbl >= {1'b0, m_q}) ? W'(dbl - {1'b0, m_q}) : dbl[W-1:0];
      b_q <= {1'b0, b_q[W-1:1]};
    end
  end

  assign y_o      = acc_q;
  assign status_o = '{busy: busy_q, done: done_q};

endmodule

[rtl/ecu_checker.sv]
// Port-level checks for the cipher unit.
module ecu_checker #(
  parameter int MOD_BITS = 31
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [((2*MOD_BITS+7)/8)*8-1:0] m_axis_tdata,
  input logic                 m_axis_tuser,
  input logic                 cfg_ready
);

  // A result waiting for the receiver is not withdrawn.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transaction withdrawn");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // A missing inverse yields a zero plaintext and a zero second word.
  a_no_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("no_inverse with non-zero data");

  // The configuration channel never applies back-pressure.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready)
    else $error("configuration channel stalled");

endmodule

bind elgamal_cipher_unit ecu_checker #(.MOD_BITS(MOD_BITS)) u_ecu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_ready     (cfg_ready)
);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int MOD_BITS = 31;
  localparam bit [MOD_BITS-1:0] FIELD_MAX = 31'h7fff_ffff;
  localparam bit [MOD_BITS-1:0] PRIME_MAX = 31'h7fff_ffff;

  localparam logic [1:0] REG_MODULUS   = 2'd0;
  localparam logic [1:0] REG_GENERATOR = 2'd1;
  localparam logic [1:0] REG_PRIV_KEY  = 2'd2;
  localparam logic [1:0] REG_PUB_KEY   = 2'd3;

  typedef enum bit {OP_ENCRYPT = 1'b0, OP_DECRYPT = 1'b1} cipher_op_e;

  typedef struct {
    bit [MOD_BITS-1:0] first;
    bit [MOD_BITS-1:0] second;
    bit                no_inv;
  } cipher_result_t;

  // Holds a private copy of the key registers, computes the expected
  // result of every accepted transaction and checks the results in order.
  class cipher_scoreboard;
    bit [63:0] modulus, generator, priv_key, pub_key;
    cipher_result_t result_q[$];
    int errors;

    function new();
      modulus = 11; generator = 2; priv_key = 8; pub_key = 3;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, bit [MOD_BITS-1:0] v);
      case (idx)
        REG_MODULUS:   modulus   = 64'(v);
        REG_GENERATOR: generator = 64'(v);
        REG_PRIV_KEY:  priv_key  = 64'(v);
        REG_PUB_KEY:   pub_key   = 64'(v);
        default:       ;
      endcase
    endfunction

    function bit [63:0] mul_mod(bit [63:0] a, bit [63:0] b, bit [63:0] m);
      bit [63:0] acc;
      acc = 0;
      while (b != 0) begin
        if (b[0]) begin
          acc += a;
          if (acc >= m) acc -= m;
        end
        a += a;
        if (a >= m) a -= m;
        b >>= 1;
      end
      return acc;
    endfunction

    function bit [63:0] pow_mod(bit [63:0] base, bit [63:0] e, bit [63:0] m);
      bit [63:0] acc, sq;
      acc = 1 % m;
      sq = base % m;
      while (e != 0) begin
        if (e[0]) acc = mul_mod(acc, sq, m);
        sq = mul_mod(sq, sq, m);
        e >>= 1;
      end
      return acc;
    endfunction

    // Extended Euclid; the coefficient is kept reduced into [0, m).
    function bit find_inverse(bit [63:0] s, bit [63:0] m, output bit [63:0] inv);
      bit [63:0] r0, r1, t0, t1, q, rn, qt, tn;
      r0 = m; r1 = s % m; t0 = 0; t1 = 1 % m;
      inv = 0;
      while (r1 != 0) begin
        q  = r0 / r1;
        rn = r0 - q * r1;
        qt = mul_mod(q % m, t1, m);
        tn = (t0 >= qt) ? t0 - qt : t0 + (m - qt);
        r0 = r1; r1 = rn; t0 = t1; t1 = tn;
      end
      if (r0 != 1) return 1'b0;
      inv = t0 % m;
      return 1'b1;
    endfunction

    function cipher_result_t predict(cipher_op_e op, bit [MOD_BITS-1:0] a,
                                     bit [MOD_BITS-1:0] b, bit [MOD_BITS-1:0] n);
      cipher_result_t res;
      bit [63:0] p, s, inv;
      res = '{0, 0, 0};
      p = modulus;
      if (p != 0) begin
        if (op == OP_ENCRYPT) begin
          res.first  = MOD_BITS'(pow_mod(generator, 64'(n), p));
          res.second = MOD_BITS'(mul_mod(pow_mod(pub_key, 64'(n), p), 64'(a) % p, p));
        end else begin
          s = pow_mod(64'(a), priv_key, p);
          if (find_inverse(s, p, inv)) res.first = MOD_BITS'(mul_mod(64'(b) % p, inv, p));
          else res.no_inv = 1'b1;
        end
      end
      return res;
    endfunction

    function void note_item(cipher_op_e op, bit [MOD_BITS-1:0] a,
                            bit [MOD_BITS-1:0] b, bit [MOD_BITS-1:0] n);
      result_q.push_back(predict(op, a, b, n));
    endfunction

    function void check_result(bit [MOD_BITS-1:0] first, bit [MOD_BITS-1:0] second,
                               bit no_inv);
      cipher_result_t exp_res;
      if (result_q.size() == 0) begin
        $display("%0t: result with nothing expected: first %0d second %0d flag %0d",
                 $time, first, second, no_inv);
        errors++;
        return;
      end
      exp_res = result_q.pop_front();
      if (first != exp_res.first) begin
        $display("%0t: result_first expected %0d actual %0d", $time, exp_res.first, first);
        errors++;
      end
      if (second != exp_res.second) begin
        $display("%0t: result_second expected %0d actual %0d",
                 $time, exp_res.second, second);
        errors++;
      end
      if (no_inv != exp_res.no_inv) begin
        $display("%0t: no_inverse expected %0d actual %0d", $time, exp_res.no_inv, no_inv);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [MOD_BITS-1:0] cfg_data;

  cipher_scoreboard sb = new();
  int hold_cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  elgamal_cipher_unit #(.MOD_BITS(MOD_BITS)) u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid, .cfg_ready,
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Result side: check each transaction and stall on a pattern that switches
  // between always ready, random and mostly stalled. A requested hold-off
  // overrides the pattern.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata[30:0], m_axis_tdata[61:31], m_axis_tuser);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        if (stall_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          stall_left = $urandom_range(1, 300);
        end
        stall_left--;
        case (stall_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, bit [MOD_BITS-1:0] v);
    cfg_index <= idx;
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_keys(bit [MOD_BITS-1:0] p, bit [MOD_BITS-1:0] g,
                          bit [MOD_BITS-1:0] x, bit [MOD_BITS-1:0] y);
    write_reg(REG_MODULUS, p);
    write_reg(REG_GENERATOR, g);
    write_reg(REG_PRIV_KEY, x);
    write_reg(REG_PUB_KEY, y);
  endtask

  // Offers one transaction and returns at the edge where it is taken; valid
  // is left high so that a burst can follow without a gap.
  task automatic push_item(cipher_op_e op, bit [MOD_BITS-1:0] a,
                           bit [MOD_BITS-1:0] b, bit [MOD_BITS-1:0] n);
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, n, b, a};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, a, b, n);
  endtask

  task automatic single(cipher_op_e op, bit [MOD_BITS-1:0] a,
                        bit [MOD_BITS-1:0] b, bit [MOD_BITS-1:0] n);
    push_item(op, a, b, n);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every expected result has come, plus a short settling time.
  task automatic drain();
    while (sb.result_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  function automatic bit [MOD_BITS-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return MOD_BITS'($urandom_range(0, 20));
      1: return FIELD_MAX - MOD_BITS'($urandom_range(0, 3));
      default: return MOD_BITS'($urandom) & FIELD_MAX;
    endcase
  endfunction

  // Genuine ciphertexts for decryption and plain encryptions in equal shares,
  // plus decryptions of arbitrary pairs, sent in bursts with random gaps.
  task automatic random_items(int count);
    int burst, gap, kind;
    bit [MOD_BITS-1:0] m, r;
    cipher_result_t ct;
    while (count > 0) begin
      burst = $urandom_range(1, 6);
      for (int i = 0; i < burst && count > 0; i++) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          push_item(OP_ENCRYPT, rand_value(), rand_value(), rand_value());
        end else if (kind < 8) begin
          m = rand_value();
          r = rand_value();
          ct = sb.predict(OP_ENCRYPT, m, 0, r);
          push_item(OP_DECRYPT, ct.first, ct.second, rand_value());
        end else begin
          push_item(OP_DECRYPT, rand_value(), rand_value(), rand_value());
        end
        count--;
      end
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6000) : $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    bit [MOD_BITS-1:0] x;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= OP_ENCRYPT;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_MODULUS;
    cfg_data      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default keys: zero exponent, field extremes, shared secret of zero
    // (no inverse), unreduced operands.
    single(OP_ENCRYPT, 0, 0, 0);
    single(OP_ENCRYPT, FIELD_MAX, FIELD_MAX, FIELD_MAX);
    single(OP_ENCRYPT, 5, 0, 1);
    single(OP_DECRYPT, 0, 7, 0);
    single(OP_DECRYPT, 11, 7, 0);
    single(OP_DECRYPT, FIELD_MAX, FIELD_MAX, FIELD_MAX);
    single(OP_DECRYPT, 2, 23, 0);
    single(OP_DECRYPT, 1, 0, 0);
    random_items(10);
    drain();

    // Largest prime modulus with a consistent key pair.
    x = MOD_BITS'($urandom) & FIELD_MAX;
    set_keys(PRIME_MAX, 7, x, MOD_BITS'(sb.pow_mod(7, 64'(x), 64'(PRIME_MAX))));
    random_items(60);
    drain();
    // Receiver holds off for a long time while the sender keeps going, so
    // the output register fills and the input stalls.
    hold_cycles = 20000;
    for (int i = 0; i < 4; i++) push_item(OP_ENCRYPT, rand_value(), 0, rand_value());
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    drain();

    // Generator congruent to zero and a zero private key.
    set_keys(PRIME_MAX, FIELD_MAX, 0, FIELD_MAX);
    single(OP_ENCRYPT, 9, 0, 0);
    single(OP_ENCRYPT, 9, 0, 5);
    single(OP_DECRYPT, 0, 12345, 0);
    random_items(8);
    drain();

    // Modulus zero: every field is zero.
    set_keys(0, 3, 5, 6);
    single(OP_DECRYPT, 0, 0, 0);
    random_items(6);
    drain();

    // Modulus one: everything reduces to zero and the inverse exists.
    set_keys(1, 0, FIELD_MAX, 0);
    single(OP_DECRYPT, 0, 4, 0);
    random_items(6);
    drain();

    // Composite modulus, so shared secrets may share a factor with it.
    set_keys(15, 2, 5, 2);
    single(OP_DECRYPT, 3, 7, 0);
    single(OP_DECRYPT, 7, 7, 0);
    random_items(15);
    drain();

    // Mid-sized prime with unreduced generator.
    x = MOD_BITS'($urandom_range(1, 100000));
    set_keys(65521, 65521 + 3, x, MOD_BITS'(sb.pow_mod(3, 64'(x), 65521)));
    random_items(40);
    drain();

    if (sb.errors == 0 && sb.result_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[elgamal_cipher_unit.f]
rtl/ecu_pkg.sv
rtl/ecu_divmod.sv
rtl/ecu_mulmod.sv
rtl/elgamal_cipher_unit.sv
rtl/ecu_checker.sv
tb/tb.sv
